// ----- hdl/window_smoothness_weight_core_assert.svh -----
// Assertion macros for the window smoothness weight core.
// Used by the controller and datapath; needs a clock and an active-low reset.
`ifndef WINDOW_SMOOTHNESS_WEIGHT_CORE_ASSERT_SVH
`define WINDOW_SMOOTHNESS_WEIGHT_CORE_ASSERT_SVH

// same-cycle implication
`define WSWC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define WSWC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- hdl/wswc_pkg.sv -----
// Shared types and constants for the window smoothness weight core.
// No dependencies.
package wswc_pkg;

  localparam int MAX_WIDTH_DEF = 4096;
  localparam logic [12:0] LINE_WIDTH_RST = 13'd1024;
  localparam logic [15:0] EPS_Q15 = 16'd33;
  localparam logic [15:0] ONE_Q15 = 16'd32768;

  // last step index of each iterative phase
  localparam logic [4:0] ACC_LAST = 5'd24;
  localparam logic [4:0] ROOT_LAST = 5'd20;
  localparam logic [4:0] DIV_LAST = 5'd21;

  typedef enum logic [3:0] {
    ST_IDLE, ST_LOAD, ST_ACC, ST_SQ, ST_DIFF, ST_ROOT,
    ST_TINI, ST_SMUL, ST_WINI, ST_DIVW, ST_FIN
  } state_t;

  typedef struct packed {
    logic       take;
    logic       load;
    logic       acc;
    logic       sq;
    logic       diff;
    logic       root;
    logic       tini;
    logic       div;
    logic       smul;
    logic       wini;
    logic       emit;
    logic [4:0] idx;
  } cmd_t;

  typedef struct packed {
    logic out_busy;
  } status_t;

endpackage

// ----- hdl/wswc_ctrl.sv -----
// Controller for the window smoothness weight core: sequences one transfer
// through load, accumulate, square root, scaling and the mean division. Uses wswc_pkg.
`include "window_smoothness_weight_core_assert.svh"

module wswc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  wswc_pkg::status_t status,
  output wswc_pkg::cmd_t    cmd
);

  wswc_pkg::state_t state_r, state_nxt;
  logic [4:0] cnt_r, cnt_nxt;

  // state and step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= wswc_pkg::ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = '0;
    cmd       = '0;
    cmd.idx   = cnt_r;
    in_ready  = 1'b0;
    case (state_r)
      wswc_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take  = 1'b1;
          state_nxt = wswc_pkg::ST_LOAD;
        end
      end
      wswc_pkg::ST_LOAD: begin
        cmd.load  = 1'b1;
        state_nxt = wswc_pkg::ST_ACC;
      end
      wswc_pkg::ST_ACC: begin
        cmd.acc = 1'b1;
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == wswc_pkg::ACC_LAST) begin
          cnt_nxt   = '0;
          state_nxt = wswc_pkg::ST_SQ;
        end
      end
      wswc_pkg::ST_SQ: begin
        cmd.sq    = 1'b1;
        state_nxt = wswc_pkg::ST_DIFF;
      end
      wswc_pkg::ST_DIFF: begin
        cmd.diff  = 1'b1;
        state_nxt = wswc_pkg::ST_ROOT;
      end
      wswc_pkg::ST_ROOT: begin
        cmd.root = 1'b1;
        cnt_nxt  = cnt_r + 5'd1;
        if (cnt_r == wswc_pkg::ROOT_LAST) begin
          cnt_nxt   = '0;
          state_nxt = wswc_pkg::ST_TINI;
        end
      end
      wswc_pkg::ST_TINI: begin
        cmd.tini  = 1'b1;
        state_nxt = wswc_pkg::ST_SMUL;
      end
      wswc_pkg::ST_SMUL: begin
        cmd.smul  = 1'b1;
        state_nxt = wswc_pkg::ST_WINI;
      end
      wswc_pkg::ST_WINI: begin
        cmd.wini  = 1'b1;
        state_nxt = wswc_pkg::ST_DIVW;
      end
      wswc_pkg::ST_DIVW: begin
        cmd.div = 1'b1;
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == wswc_pkg::DIV_LAST) begin
          cnt_nxt   = '0;
          state_nxt = wswc_pkg::ST_FIN;
        end
      end
      wswc_pkg::ST_FIN: begin
        // wait for a free output slot
        if (!status.out_busy) begin
          cmd.emit  = 1'b1;
          state_nxt = wswc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = wswc_pkg::ST_IDLE;
      end
    endcase
  end

  `WSWC_ASSERT_NXT(a_take_loads, clk, rst_n, cmd.take, state_r == wswc_pkg::ST_LOAD)
  `WSWC_ASSERT_IMP(a_emit_free, clk, rst_n, cmd.emit, !status.out_busy)
  `WSWC_ASSERT_IMP(a_cnt_bound, clk, rst_n, 1'b1, cnt_r <= wswc_pkg::ACC_LAST)

endmodule

// ----- hdl/wswc_dp.sv -----
// Datapath for the window smoothness weight core: line memory, 5x5 window,
// sums, bit-serial square root, reciprocal scaling, mean divider, output register.
// Uses wswc_pkg.
`include "window_smoothness_weight_core_assert.svh"

module wswc_dp #(
  parameter int MAX_WIDTH = wswc_pkg::MAX_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  input  logic [12:0]       cfg_line_width,
  input  logic [15:0]       in_sample,
  input  logic              in_frame_start,
  input  wswc_pkg::cmd_t    cmd,
  output wswc_pkg::status_t status,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [15:0]       out_weight,
  output logic              out_weight_valid,
  output logic [11:0]       out_center_column
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam logic [12:0] WLIM = (MAX_WIDTH < 4096) ? 13'(MAX_WIDTH) : 13'd4096;
  // ceil(2^30 / 25); exact floor division for dividends below 2^30
  localparam logic [25:0] RECIP25 = 26'd42949673;

  // configuration
  logic [12:0] cfg_lw_r;
  logic [12:0] eff_w;

  always_ff @(posedge clk) begin
    if (!rst_n) cfg_lw_r <= wswc_pkg::LINE_WIDTH_RST;
    else if (cfg_valid) cfg_lw_r <= cfg_line_width;
  end

  always_comb begin
    eff_w = cfg_lw_r;
    if (eff_w < 13'd5) eff_w = 13'd5;
    if (eff_w > WLIM) eff_w = WLIM;
  end

  // position counters, wrap before the sample is taken
  logic [11:0] col_cnt_r, row_cnt_r;
  logic [11:0] c0, r0, c1, r1;
  logic [11:0] col_r, row_r;

  always_comb begin
    c0 = in_frame_start ? 12'd0 : col_cnt_r;
    r0 = in_frame_start ? 12'd0 : row_cnt_r;
    c1 = c0;
    r1 = r0;
    if ({1'b0, c0} >= eff_w) begin
      c1 = '0;
      if (r0 != 12'hFFF) r1 = r0 + 12'd1;
    end
  end

  // line memory: one word holds the four stored rows of a column
  logic [63:0] mem [MAX_WIDTH];
  logic [63:0] rd_r;
  logic [15:0] x_r;

  always_ff @(posedge clk) begin
    if (cmd.take) rd_r <= mem[AW'(c1)];
    if (cmd.load) mem[AW'(col_r)] <= {x_r, rd_r[63:16]};
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      x_r   <= (in_sample > wswc_pkg::ONE_Q15) ? wswc_pkg::ONE_Q15 : in_sample;
      col_r <= c1;
      row_r <= r1;
    end
  end

  // post-sample counter update
  logic [12:0] cn;
  assign cn = {1'b0, col_r} + 13'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r <= '0;
      row_cnt_r <= '0;
    end else if (cmd.load) begin
      if (cn >= eff_w) begin
        col_cnt_r <= '0;
        row_cnt_r <= (row_r != 12'hFFF) ? row_r + 12'd1 : row_r;
      end else begin
        col_cnt_r <= cn[11:0];
        row_cnt_r <= row_r;
      end
    end
  end

  // 5x5 window, each row shifts left and takes the new column
  logic [15:0] win_r [25];
  logic [15:0] newcol [5];
  logic        valid_r;

  always_comb begin
    for (int r = 0; r < 4; r++) newcol[r] = rd_r[16*r +: 16];
    newcol[4] = x_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 25; i++) win_r[i] <= '0;
    end else if (cmd.load) begin
      for (int r = 0; r < 5; r++) begin
        for (int k = 0; k < 4; k++) win_r[r*5+k] <= win_r[r*5+k+1];
        win_r[r*5+4] <= newcol[r];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) valid_r <= (row_r >= 12'd4) && (col_r >= 12'd4);
  end

  // sums over the window, one sample per cycle
  logic [15:0] ax;
  logic [31:0] axx;
  logic [19:0] s_r, v_r;
  logic [34:0] q_r;
  logic [4:0]  c_r;

  assign ax  = win_r[cmd.idx];
  assign axx = ax * ax;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      s_r <= '0;
      q_r <= '0;
      v_r <= '0;
      c_r <= '0;
    end else if (cmd.acc) begin
      s_r <= s_r + 20'(ax);
      q_r <= q_r + 35'(axx);
      if (ax < wswc_pkg::ONE_Q15) begin
        v_r <= v_r + 20'(ax);
        c_r <= c_r + 5'd1;
      end
    end
  end

  // D = 25Q - S*S, then isqrt(16D) two bits per step
  logic [39:0] sq_r, dd;
  logic [41:0] rad_r;
  logic [20:0] sroot_r;
  logic [22:0] srem_r;
  logic [24:0] st2, strial;

  assign dd     = 40'(q_r) * 40'd25 - sq_r;
  assign st2    = {srem_r, rad_r[41:40]};
  assign strial = {2'b00, sroot_r, 2'b01};

  always_ff @(posedge clk) begin
    if (cmd.sq) sq_r <= s_r * s_r;
    if (cmd.diff) begin
      rad_r   <= {dd[37:0], 4'b0000};
      sroot_r <= '0;
      srem_r  <= '0;
    end else if (cmd.root) begin
      rad_r <= {rad_r[39:0], 2'b00};
      if (st2 >= strial) begin
        srem_r  <= 23'(st2 - strial);
        sroot_r <= {sroot_r[19:0], 1'b1};
      end else begin
        srem_r  <= st2[22:0];
        sroot_r <= {sroot_r[19:0], 1'b0};
      end
    end
  end

  // deviation scale by reciprocal multiply, restoring divider for the mean
  logic [21:0] dq_r;
  logic [4:0]  drem_r, dvs_r;
  logic [5:0]  dt2;
  logic [15:0] sm;
  logic [4:0]  cc, cc_r;
  logic [35:0] num_r;
  logic [21:0] tx;
  logic [47:0] tprod;

  assign dt2   = {drem_r, dq_r[21]};
  assign tx    = 22'(sroot_r) + 22'd12;
  assign tprod = 48'(tx) * 48'(RECIP25);

  always_comb begin
    sm = (dq_r < 22'd32735) ? 16'(17'd32768 - 17'(dq_r)) : wswc_pkg::EPS_Q15;
    cc = (c_r == 5'd0) ? 5'd1 : c_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.tini) begin
      dq_r <= 22'(tprod[47:30]);
    end else if (cmd.wini) begin
      dq_r   <= 22'(num_r[35:15]);
      drem_r <= '0;
      dvs_r  <= cc_r;
    end else if (cmd.div) begin
      if (dt2 >= {1'b0, dvs_r}) begin
        drem_r <= 5'(dt2 - {1'b0, dvs_r});
        dq_r   <= {dq_r[20:0], 1'b1};
      end else begin
        drem_r <= dt2[4:0];
        dq_r   <= {dq_r[20:0], 1'b0};
      end
    end
    if (cmd.smul) begin
      num_r <= 36'(sm) * 36'(v_r) + {17'd0, cc, 14'd0};
      cc_r  <= cc;
    end
  end

  // result selection and output register
  logic [15:0] wsel;
  logic        out_valid_r;
  logic [15:0] out_weight_r;
  logic        out_wv_r;
  logic [11:0] out_col_r;

  always_comb begin
    wsel = (dq_r < 22'(wswc_pkg::EPS_Q15)) ? wswc_pkg::EPS_Q15 : dq_r[15:0];
    if (win_r[12] >= wswc_pkg::ONE_Q15) wsel = wswc_pkg::EPS_Q15;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (cmd.emit) out_valid_r <= 1'b1;
    else if (out_ready) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_weight_r <= valid_r ? wsel : 16'd0;
      out_wv_r     <= valid_r;
      out_col_r    <= valid_r ? col_r - 12'd2 : 12'd0;
    end
  end

  assign status.out_busy   = out_valid_r && !out_ready;
  assign out_valid         = out_valid_r;
  assign out_weight        = out_weight_r;
  assign out_weight_valid  = out_wv_r;
  assign out_center_column = out_col_r;

  `WSWC_ASSERT_NXT(a_emit_shows, clk, rst_n, cmd.emit, out_valid_r)
  `WSWC_ASSERT_IMP(a_inval_zero, clk, rst_n, out_valid_r && !out_wv_r,
                   out_weight_r == 16'd0 && out_col_r == 12'd0)
  `WSWC_ASSERT_IMP(a_wt_floor, clk, rst_n, out_valid_r && out_wv_r,
                   out_weight_r >= wswc_pkg::EPS_Q15)

endmodule

// ----- hdl/window_smoothness_weight_core.sv -----
// Window smoothness weight core: accepts one sample per transfer and returns
// one weight per sample. A new sample is taken only after the previous one has
// gone through the 25-step window sum, the 21-step square root and the 22-step
// mean division and its weight has been placed in a free output slot.
// Reset (rst_n low, synchronous) clears counters, window and line_width=1024.
// The line memory is not cleared.
module window_smoothness_weight_core #(
  parameter int MAX_WIDTH = wswc_pkg::MAX_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [12:0] cfg_line_width,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] in_sample,
  input  logic        in_frame_start,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_weight,
  output logic        out_weight_valid,
  output logic [11:0] out_center_column
);

  wswc_pkg::cmd_t    cmd;
  wswc_pkg::status_t status;

  assign cfg_ready = 1'b1;

  wswc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  wswc_dp #(.MAX_WIDTH(MAX_WIDTH)) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_line_width    (cfg_line_width),
    .in_sample         (in_sample),
    .in_frame_start    (in_frame_start),
    .cmd               (cmd),
    .status            (status),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_weight        (out_weight),
    .out_weight_valid  (out_weight_valid),
    .out_center_column (out_center_column)
  );

endmodule

// ----- tb/window_smoothness_weight_core_tb.sv -----
// Testbench for window_smoothness_weight_core: directed and random sample planes,
// checked against a built-in weight predictor. Depends on wswc_pkg and the core RTL.
`timescale 1ns / 1ps

module window_smoothness_weight_core_tb;

  localparam int MAXW = wswc_pkg::MAX_WIDTH_DEF;
  localparam longint CYCLE_LIMIT = 3000000;
  localparam int SETTLE_CYCLES = 120;

  typedef struct {
    logic [15:0] weight;
    logic        wvalid;
    logic [11:0] column;
  } weight_rec_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [12:0] cfg_line_width = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [15:0] in_sample = '0;
  logic        in_frame_start = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] out_weight;
  logic        out_weight_valid;
  logic [11:0] out_center_column;

  // predictor state
  logic [12:0] width_reg;
  logic [15:0] line_mem [0:4*MAXW-1];
  logic [15:0] win [0:24];
  int unsigned col_cnt, row_cnt;
  weight_rec_t pending_weights[$];

  int  fails = 0;
  bit  send_gaps = 1'b1;
  bit  recv_gaps = 1'b1;
  bit  hold_req = 1'b0;
  int  hold_cnt = 0;
  int  stall_cnt = 0;
  longint cycles = 0;

  window_smoothness_weight_core dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_line_width(cfg_line_width),
    .in_valid(in_valid), .in_ready(in_ready), .in_sample(in_sample),
    .in_frame_start(in_frame_start),
    .out_valid(out_valid), .out_ready(out_ready), .out_weight(out_weight),
    .out_weight_valid(out_weight_valid), .out_center_column(out_center_column)
  );

  always #5 clk = ~clk;

  // floor square root
  function automatic longint unsigned isqrt(input longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // smoothness-scaled mean of the unclipped window samples
  function automatic logic [15:0] smooth_weight();
    longint unsigned s, q, v, c, d, t, sm, wt, x;
    s = 0; q = 0; v = 0; c = 0;
    if (win[12] >= wswc_pkg::ONE_Q15) return wswc_pkg::EPS_Q15;
    for (int i = 0; i < 25; i++) begin
      x = win[i];
      s += x;
      q += x * x;
      if (x < wswc_pkg::ONE_Q15) begin
        v += x;
        c++;
      end
    end
    d = 25 * q - s * s;
    t = (isqrt(16 * d) + 12) / 25;
    sm = (t < 32735) ? (32768 - t) : 33;
    if (c == 0) c = 1;
    wt = (sm * v + c * 16384) / (c * 32768);
    if (wt < 33) wt = 33;
    return wt[15:0];
  endfunction

  // advance the predictor by one accepted sample
  function automatic void predict_weight(input logic [15:0] smp, input logic fs);
    int unsigned w, col;
    logic [15:0] x;
    logic [15:0] newcol [0:4];
    weight_rec_t rec;
    w = width_reg;
    if (w < 5) w = 5;
    if (w > MAXW) w = MAXW;
    x = (smp > wswc_pkg::ONE_Q15) ? wswc_pkg::ONE_Q15 : smp;
    if (fs) begin
      col_cnt = 0;
      row_cnt = 0;
    end
    if (col_cnt >= w) begin
      col_cnt = 0;
      if (row_cnt < 4095) row_cnt++;
    end
    col = col_cnt;
    for (int r = 0; r < 4; r++) newcol[r] = line_mem[r*MAXW + col];
    newcol[4] = x;
    for (int r = 0; r < 3; r++) line_mem[r*MAXW + col] = line_mem[(r+1)*MAXW + col];
    line_mem[3*MAXW + col] = x;
    for (int r = 0; r < 5; r++) begin
      for (int k = 0; k < 4; k++) win[r*5+k] = win[r*5+k+1];
      win[r*5+4] = newcol[r];
    end
    if (row_cnt >= 4 && col >= 4) begin
      rec.weight = smooth_weight();
      rec.wvalid = 1'b1;
      rec.column = 12'(col - 2);
    end else begin
      rec.weight = '0;
      rec.wvalid = 1'b0;
      rec.column = '0;
    end
    pending_weights.push_back(rec);
    col_cnt = col + 1;
    if (col_cnt >= w) begin
      col_cnt = 0;
      if (row_cnt < 4095) row_cnt++;
    end
  endfunction

  // result check
  always @(posedge clk) begin
    weight_rec_t e;
    if (rst_n && out_valid && out_ready) begin
      if (pending_weights.size() == 0) begin
        $error("unexpected weight transfer: weight %0d", out_weight);
        fails++;
      end else begin
        e = pending_weights.pop_front();
        if (out_weight !== e.weight) begin
          $error("weight: expected %0d, got %0d", e.weight, out_weight);
          fails++;
        end
        if (out_weight_valid !== e.wvalid) begin
          $error("weight_valid: expected %0d, got %0d", e.wvalid, out_weight_valid);
          fails++;
        end
        if (out_center_column !== e.column) begin
          $error("center_column: expected %0d, got %0d", e.column, out_center_column);
          fails++;
        end
      end
    end
  end

  // receiver: random stall bursts and one long hold-off
  always @(posedge clk) begin
    if (hold_req) begin
      hold_req <= 1'b0;
      hold_cnt <= 2000;
      out_ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_ready <= (hold_cnt == 1);
    end else if (stall_cnt > 0) begin
      stall_cnt <= stall_cnt - 1;
      out_ready <= (stall_cnt == 1);
    end else if (recv_gaps && $urandom_range(0, 5) == 0) begin
      stall_cnt <= $urandom_range(1, 14);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // one sample transfer; valid stays high unless a gap follows
  task automatic send_sample(input logic [15:0] smp, input logic fs);
    in_valid <= 1'b1;
    in_sample <= smp;
    in_frame_start <= fs;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_weight(smp, fs);
    if (send_gaps && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_weights.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // register write while idle
  task automatic write_width(input logic [12:0] w);
    drain();
    cfg_valid <= 1'b1;
    cfg_line_width <= w;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    width_reg = w;
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [15:0] rand_sample(input logic [15:0] base);
    int m;
    m = $urandom_range(0, 99);
    if (m < 45) return 16'(base + $urandom_range(0, 600));
    if (m < 55) return wswc_pkg::ONE_Q15;
    if (m < 63) return 16'($urandom_range(32769, 65535));
    if (m < 78) return 16'($urandom);
    if (m < 86) return 16'd0;
    return 16'($urandom_range(0, 200));
  endfunction

  // a whole plane of random content
  task automatic send_plane(input int w, input int rows, input logic [15:0] base);
    for (int i = 0; i < w * rows; i++) begin
      if (i > 8 && $urandom_range(0, 199) == 0) send_sample(rand_sample(base), 1'b1);
      else send_sample(rand_sample(base), i == 0);
    end
  endtask

  // field extremes, clipped center, fully clipped window, flat and rough windows
  task automatic test_extremes();
    write_width(13'd5);
    send_plane(5, 5, 16'd8000);
    for (int i = 0; i < 25; i++) send_sample(wswc_pkg::ONE_Q15, i == 0);
    for (int i = 0; i < 25; i++) send_sample((i % 2) ? 16'hFFFF : 16'h0000, i == 0);
    for (int i = 0; i < 25; i++) send_sample(16'd12345, i == 0);
    for (int i = 0; i < 25; i++) begin
      send_sample((i == 12) ? wswc_pkg::ONE_Q15 : 16'd30000, i == 0);
    end
    for (int i = 0; i < 25; i++) send_sample((i == 24) ? 16'd32767 : 16'd1, i == 0);
  endtask

  // frame start inside a plane restarts the counts
  task automatic test_frame_restart();
    write_width(13'd7);
    for (int i = 0; i < 40; i++) send_sample(rand_sample(16'd20000), i == 0 || i == 23);
  endtask

  // width lowered while the column count lies beyond it
  task automatic test_width_lowered();
    write_width(13'd9);
    for (int i = 0; i < 7; i++) send_sample(rand_sample(16'd5000), i == 0);
    write_width(13'd5);
    for (int i = 0; i < 35; i++) send_sample(rand_sample(16'd5000), 1'b0);
  endtask

  // register values below, at and above the clamp limits
  task automatic test_register_extremes();
    write_width(13'd0);
    send_plane(5, 5, 16'd100);
    write_width(13'd4);
    send_plane(5, 5, 16'd31000);
    write_width(13'h1FFF);
    for (int i = 0; i < 40; i++) send_sample(rand_sample(16'd9000), i == 0);
    write_width(13'd4096);
    for (int i = 0; i < 40; i++) send_sample(rand_sample(16'd9000), i == 0);
  endtask

  // receiver holds off long; then the sender waits for a full drain mid-plane
  task automatic test_backpressure();
    write_width(13'd6);
    hold_req = 1'b1;
    for (int i = 0; i < 40; i++) send_sample(rand_sample(16'd15000), i == 0);
    drain();
    for (int i = 0; i < 20; i++) send_sample(rand_sample(16'd15000), 1'b0);
  endtask

  task automatic test_random();
    int w, rows;
    for (int n = 0; n < 950; ) begin
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 40) : $urandom_range(5, 12);
      rows = $urandom_range(5, 8);
      write_width(13'(w));
      send_plane(w, rows, 16'($urandom_range(0, 31000)));
      n += w * rows;
    end
  endtask

  // closing stretch with no idling on either side
  task automatic test_no_idle();
    send_gaps = 1'b0;
    recv_gaps = 1'b0;
    write_width(13'd8);
    send_plane(8, 6, 16'd24000);
  endtask

  initial begin
    width_reg = wswc_pkg::LINE_WIDTH_RST;
    col_cnt = 0;
    row_cnt = 0;
    for (int i = 0; i < 4*MAXW; i++) line_mem[i] = '0;
    for (int i = 0; i < 25; i++) win[i] = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_extremes();
    test_frame_restart();
    test_width_lowered();
    test_register_extremes();
    test_backpressure();
    test_random();
    test_no_idle();
    drain();
    if (fails == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
